// File: rtl/core/waob_pkg.sv
// Shared types and constants of the windowed alpha overlay blend.
// Holds the register map, status codes and the pipeline payload structs.
// No dependencies.
package waob_pkg;

    // Largest picture side accepted as a valid setup
    localparam int MAX_DIM = 4096;

    // Configuration bus width and address width (seven word registers)
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    // Valid transparency window, Q8 (0.1 .. 0.9)
    localparam logic [7:0] T_MIN = 8'd26;
    localparam logic [7:0] T_MAX = 8'd230;

    // 1.0 in Q8
    localparam logic [8:0] WEIGHT_ONE = 9'd256;

    // Register index on the configuration port (paddr[4:2])
    typedef enum logic [2:0] {
        REG_TRANSP    = 3'd0,
        REG_LOGO_LEFT = 3'd1,
        REG_LOGO_TOP  = 3'd2,
        REG_LOGO_COLS = 3'd3,
        REG_LOGO_ROWS = 3'd4,
        REG_PIC_COLS  = 3'd5,
        REG_PIC_ROWS  = 3'd6
    } t_reg_idx;

    // Result status
    typedef enum logic [1:0] {
        ST_PASS    = 2'd0,
        ST_BLEND   = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]  transp;
        logic [11:0] logo_left;
        logic [11:0] logo_top;
        logic [12:0] logo_cols;
        logic [12:0] logo_rows;
        logic [12:0] pic_cols;
        logic [12:0] pic_rows;
    } t_cfg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    // Request as it enters the pipe
    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
        t_pixel      pic;
        t_pixel      logo;
        logic [7:0]  alpha;
    } t_in_item;

    // After window check and alpha product
    typedef struct packed {
        t_pixel      pic;
        t_pixel      logo;
        logic [15:0] prod;
        t_status     status;
    } t_front_item;

    // After the divide by 255
    typedef struct packed {
        t_pixel     pic;
        t_pixel     logo;
        logic [8:0] weight;
        t_status    status;
    } t_weight_item;

    typedef struct packed {
        t_pixel  px;
        t_status status;
    } t_out_item;

endpackage

// File: rtl/core/waob_cfg.sv
// Configuration register file with APB-style access.
// Depends on waob_pkg for the register map and the t_cfg struct.
module waob_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [waob_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [waob_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [waob_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    output waob_pkg::t_cfg                     o_cfg
);
    import waob_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;

    // Register writes; unmapped index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.transp    <= 8'd128;
            r_cfg.logo_left <= '0;
            r_cfg.logo_top  <= '0;
            r_cfg.logo_cols <= 13'd1;
            r_cfg.logo_rows <= 13'd1;
            r_cfg.pic_cols  <= 13'd1;
            r_cfg.pic_rows  <= 13'd1;
        end else if (w_wr) begin
            case (w_idx)
                REG_TRANSP:    r_cfg.transp    <= pwdata[7:0];
                REG_LOGO_LEFT: r_cfg.logo_left <= pwdata[11:0];
                REG_LOGO_TOP:  r_cfg.logo_top  <= pwdata[11:0];
                REG_LOGO_COLS: r_cfg.logo_cols <= pwdata[12:0];
                REG_LOGO_ROWS: r_cfg.logo_rows <= pwdata[12:0];
                REG_PIC_COLS:  r_cfg.pic_cols  <= pwdata[12:0];
                REG_PIC_ROWS:  r_cfg.pic_rows  <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_TRANSP:    prdata = CFG_DATA_W'(r_cfg.transp);
            REG_LOGO_LEFT: prdata = CFG_DATA_W'(r_cfg.logo_left);
            REG_LOGO_TOP:  prdata = CFG_DATA_W'(r_cfg.logo_top);
            REG_LOGO_COLS: prdata = CFG_DATA_W'(r_cfg.logo_cols);
            REG_LOGO_ROWS: prdata = CFG_DATA_W'(r_cfg.logo_rows);
            REG_PIC_COLS:  prdata = CFG_DATA_W'(r_cfg.pic_cols);
            REG_PIC_ROWS:  prdata = CFG_DATA_W'(r_cfg.pic_rows);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/waob_front.sv
// Pipe stage 1: setup check, window hit test and alpha * (1 - t) product.
// Depends on waob_pkg for t_cfg, t_in_item and t_front_item.
module waob_front #(
    parameter int MAX_DIM = waob_pkg::MAX_DIM
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  waob_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  waob_pkg::t_in_item    i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output waob_pkg::t_front_item o_item
);
    import waob_pkg::*;

    logic        r_valid;
    t_front_item r_item;
    t_front_item n_item;
    logic [13:0] w_col_end;
    logic [13:0] w_row_end;
    logic        w_t_ok;
    logic        w_dim_ok;
    logic        w_fit_ok;
    logic        w_col_hit;
    logic        w_row_hit;
    logic [8:0]  w_inv_t;
    logic [16:0] w_prod;

    // Window edges (exclusive)
    assign w_col_end = 14'(i_cfg.logo_left) + 14'(i_cfg.logo_cols);
    assign w_row_end = 14'(i_cfg.logo_top) + 14'(i_cfg.logo_rows);

    // Setup validity
    assign w_t_ok   = (i_cfg.transp >= T_MIN) && (i_cfg.transp <= T_MAX);
    assign w_dim_ok = (32'(i_cfg.pic_cols) <= 32'(MAX_DIM))
                   && (32'(i_cfg.pic_rows) <= 32'(MAX_DIM));
    assign w_fit_ok = (w_col_end <= 14'(i_cfg.pic_cols))
                   && (w_row_end <= 14'(i_cfg.pic_rows));

    // Pixel inside logo window
    assign w_col_hit = (i_item.column >= i_cfg.logo_left)
                    && (14'(i_item.column) < w_col_end);
    assign w_row_hit = (i_item.row >= i_cfg.logo_top)
                    && (14'(i_item.row) < w_row_end);

    // alpha * (256 - t), at most 255 * 256
    assign w_inv_t = WEIGHT_ONE - {1'b0, i_cfg.transp};
    assign w_prod  = {9'b0, i_item.alpha} * {8'b0, w_inv_t};

    always_comb begin
        n_item.pic  = i_item.pic;
        n_item.logo = i_item.logo;
        n_item.prod = w_prod[15:0];
        priority if (!(w_t_ok && w_dim_ok && w_fit_ok)) begin
            n_item.status = ST_INVALID;
        end else if (w_col_hit && w_row_hit) begin
            n_item.status = ST_BLEND;
        end else begin
            n_item.status = ST_PASS;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/core/waob_weight.sv
// Pipe stage 2: weight f = floor(prod / 255) by reciprocal shift and add.
// Depends on waob_pkg for t_front_item and t_weight_item.
module waob_weight (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  waob_pkg::t_front_item  i_item,
    output logic                   o_valid,
    input  logic                   i_ready,
    output waob_pkg::t_weight_item o_item
);
    import waob_pkg::*;

    logic         r_valid;
    t_weight_item r_item;
    t_weight_item n_item;
    logic [16:0]  w_sum;

    // x / 255 == (x + 1 + (x >> 8)) >> 8, exact for x up to 255 * 256
    assign w_sum = 17'(i_item.prod) + 17'd1 + 17'(i_item.prod[15:8]);

    always_comb begin
        n_item.pic    = i_item.pic;
        n_item.logo   = i_item.logo;
        n_item.weight = w_sum[16:8];
        n_item.status = i_item.status;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/core/waob_mix.sv
// Pipe stage 3: per-channel mix and output register.
// Depends on waob_pkg for t_weight_item and t_out_item.
module waob_mix (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  waob_pkg::t_weight_item i_item,
    output logic                   o_valid,
    input  logic                   i_ready,
    output waob_pkg::t_out_item    o_item
);
    import waob_pkg::*;

    logic      r_valid;
    t_out_item r_item;
    t_out_item n_item;
    t_pixel    w_mixed;

    // (pic * (256 - f) >> 8) + (logo * f >> 8), each term truncated
    function automatic logic [7:0] mix_ch(input logic [7:0] pic,
                                          input logic [7:0] logo,
                                          input logic [8:0] w);
        logic [16:0] a;
        logic [16:0] b;
        logic [8:0]  s;
        a = {9'b0, pic} * {8'b0, WEIGHT_ONE - w};
        b = {9'b0, logo} * {8'b0, w};
        s = a[16:8] + b[16:8];
        return s[7:0];
    endfunction

    assign w_mixed.blue  = mix_ch(i_item.pic.blue,  i_item.logo.blue,  i_item.weight);
    assign w_mixed.green = mix_ch(i_item.pic.green, i_item.logo.green, i_item.weight);
    assign w_mixed.red   = mix_ch(i_item.pic.red,   i_item.logo.red,   i_item.weight);

    // Only blended pixels take the mix
    always_comb begin
        n_item.status = i_item.status;
        n_item.px     = (i_item.status == ST_BLEND) ? w_mixed : i_item.pic;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/core/windowed_alpha_overlay_blend.sv
// Top level of the windowed alpha overlay blend: config port and 3-stage pipe.
// Depends on waob_pkg, waob_cfg, waob_front, waob_weight and waob_mix.
//
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+-----------------------------
// s_axis    | in        | s_axis_tvalid/s_axis_tready | tdata[79:0] pixel request
// m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata[23:0] pixel, tuser status
// apb       | in        | psel/penable/pwrite/pready  | paddr[4:2] reg, pwdata
//
// One pixel per clock sustained unless m_axis stalls; each stage output is registered.
// The stages are window check plus alpha product, divide by 255, channel mix.
// Each stage holds a valid bit and its own ready, so bubbles are squeezed out
// and a stall on m_axis backs up stage by stage without loss.
// Reset is synchronous, active low; valid bits and config registers reset to defaults.
module windowed_alpha_overlay_blend #(
    parameter int MAX_DIM = waob_pkg::MAX_DIM
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Fields from bit 0: column[11:0], row[23:12], pic_blue, pic_green,
    // pic_red, logo_blue, logo_green, logo_red, logo_alpha[79:72]
    input  logic [79:0]                     s_axis_tdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: out_blue[7:0], out_green[15:8], out_red[23:16]
    output logic [23:0]                     m_axis_tdata,
    // Fields from bit 0: status[1:0]
    output logic [1:0]                      m_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [waob_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [waob_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [waob_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import waob_pkg::*;

    t_cfg         w_cfg;
    t_in_item     w_in;
    logic         w_front_valid;
    logic         w_front_ready;
    t_front_item  w_front_item;
    logic         w_wgt_valid;
    logic         w_wgt_ready;
    t_weight_item w_wgt_item;
    t_out_item    w_out_item;

    // Unpack the request
    assign w_in.column     = s_axis_tdata[11:0];
    assign w_in.row        = s_axis_tdata[23:12];
    assign w_in.pic.blue   = s_axis_tdata[31:24];
    assign w_in.pic.green  = s_axis_tdata[39:32];
    assign w_in.pic.red    = s_axis_tdata[47:40];
    assign w_in.logo.blue  = s_axis_tdata[55:48];
    assign w_in.logo.green = s_axis_tdata[63:56];
    assign w_in.logo.red   = s_axis_tdata[71:64];
    assign w_in.alpha      = s_axis_tdata[79:72];

    waob_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    waob_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in),
        .o_valid (w_front_valid),
        .i_ready (w_front_ready),
        .o_item  (w_front_item)
    );

    waob_weight u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .o_ready (w_front_ready),
        .i_item  (w_front_item),
        .o_valid (w_wgt_valid),
        .i_ready (w_wgt_ready),
        .o_item  (w_wgt_item)
    );

    waob_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_wgt_valid),
        .o_ready (w_wgt_ready),
        .i_item  (w_wgt_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_item  (w_out_item)
    );

    // Pack the result
    assign m_axis_tdata = {w_out_item.px.red, w_out_item.px.green, w_out_item.px.blue};
    assign m_axis_tuser = w_out_item.status;

`ifndef SYNTHESIS
    // An empty output stage means the whole pipe can take a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while output stage empty");

    // A new result only appears when the weight stage held an item
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_wgt_valid))
        else $error("result appeared without a weight stage item");

    // Weight never exceeds 1.0 in Q8
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wgt_valid |-> (w_wgt_item.weight <= WEIGHT_ONE))
        else $error("blend weight above 256");

    // A stalled weight stage keeps its item until the mix stage takes it
    a_weight_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wgt_valid && !w_wgt_ready) |=> (w_wgt_valid && $stable(w_wgt_item)))
        else $error("weight stage item changed under stall");
`endif

endmodule

// File: dv/tb_windowed_alpha_overlay_blend.sv
// Self-checking testbench for windowed_alpha_overlay_blend: pixel stream plus APB setup.
// Depends on waob_pkg and the windowed_alpha_overlay_blend RTL; a scoreboard class
// predicts every blended pixel.
`timescale 1ns / 1ps

import waob_pkg::*;

// One pixel request as it travels on s_axis
typedef struct {
    logic [11:0] column;
    logic [11:0] row;
    logic [7:0]  pic_blue;
    logic [7:0]  pic_green;
    logic [7:0]  pic_red;
    logic [7:0]  logo_blue;
    logic [7:0]  logo_green;
    logic [7:0]  logo_red;
    logic [7:0]  logo_alpha;
} t_pixel_req;

// Predicted pixel on m_axis
typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    t_status    status;
} t_blended_px;

// Overlay setup: one value per register
typedef struct {
    logic [7:0]  transp;
    logic [11:0] left;
    logic [11:0] top;
    logic [12:0] lcols;
    logic [12:0] lrows;
    logic [12:0] pcols;
    logic [12:0] prows;
} t_overlay_setup;

class blend_scoreboard;
    // Shadow copy of the register file
    logic [7:0]  transp;
    logic [11:0] left;
    logic [11:0] top;
    logic [12:0] lcols;
    logic [12:0] lrows;
    logic [12:0] pcols;
    logic [12:0] prows;
    t_blended_px expected_pixels[$];
    int          errors;

    function new();
        transp = 8'd128;
        left   = '0;
        top    = '0;
        lcols  = 13'd1;
        lrows  = 13'd1;
        pcols  = 13'd1;
        prows  = 13'd1;
        errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
        case (idx)
            REG_TRANSP:    transp = value[7:0];
            REG_LOGO_LEFT: left   = value[11:0];
            REG_LOGO_TOP:  top    = value[11:0];
            REG_LOGO_COLS: lcols  = value[12:0];
            REG_LOGO_ROWS: lrows  = value[12:0];
            REG_PIC_COLS:  pcols  = value[12:0];
            REG_PIC_ROWS:  prows  = value[12:0];
            default: ;  // unmapped index: write dropped
        endcase
    endfunction

    function bit setup_ok();
        if (transp < T_MIN || transp > T_MAX) return 0;
        if (int'(pcols) > MAX_DIM || int'(prows) > MAX_DIM) return 0;
        if (int'(left) + int'(lcols) > int'(pcols)) return 0;
        if (int'(top) + int'(lrows) > int'(prows)) return 0;
        return 1;
    endfunction

    // Two truncated terms; their sum stays within 8 bits
    function logic [7:0] mix_channel(logic [7:0] pic, logic [7:0] logo, int unsigned weight);
        int unsigned keep;
        int unsigned add;
        keep = (int'(pic) * (256 - weight)) >> 8;
        add  = (int'(logo) * weight) >> 8;
        return 8'(keep + add);
    endfunction

    function t_blended_px blend_pixel(t_pixel_req r);
        t_blended_px p;
        int unsigned weight;
        p.blue   = r.pic_blue;
        p.green  = r.pic_green;
        p.red    = r.pic_red;
        p.status = ST_PASS;
        if (!setup_ok()) begin
            p.status = ST_INVALID;
        end else if (int'(r.column) >= int'(left) && int'(r.column) < int'(left) + int'(lcols)
                     && int'(r.row) >= int'(top) && int'(r.row) < int'(top) + int'(lrows)) begin
            weight   = (int'(r.logo_alpha) * (256 - int'(transp))) / 255;
            p.blue   = mix_channel(r.pic_blue, r.logo_blue, weight);
            p.green  = mix_channel(r.pic_green, r.logo_green, weight);
            p.red    = mix_channel(r.pic_red, r.logo_red, weight);
            p.status = ST_BLEND;
        end
        return p;
    endfunction

    function void note_request(t_pixel_req r);
        expected_pixels.push_back(blend_pixel(r));
    endfunction

    function void check_result(logic [23:0] data, logic [1:0] user);
        t_blended_px e;
        if (expected_pixels.size() == 0) begin
            $error("pixel result with no request pending: data %06h status %0d", data, user);
            errors++;
            return;
        end
        e = expected_pixels.pop_front();
        if (data[7:0] !== e.blue) begin
            $error("out_blue: expected %0d, got %0d", e.blue, data[7:0]);
            errors++;
        end
        if (data[15:8] !== e.green) begin
            $error("out_green: expected %0d, got %0d", e.green, data[15:8]);
            errors++;
        end
        if (data[23:16] !== e.red) begin
            $error("out_red: expected %0d, got %0d", e.red, data[23:16]);
            errors++;
        end
        if (user !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, user);
            errors++;
        end
    endfunction

    function int pending();
        return expected_pixels.size();
    endfunction
endclass

module tb_windowed_alpha_overlay_blend;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic [79:0]           s_axis_tdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [23:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    blend_scoreboard sb = new();
    bit              no_gaps = 0;

    windowed_alpha_overlay_blend DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // Result side: random back-pressure, none during the no-gap stretch
    always @(negedge i_clk) begin
        m_axis_tready <= no_gaps || ($urandom_range(99) >= 19);
    end

    // Check every result taken at a rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Hard stop in case the stream hangs
    initial begin
        #2_000_000;
        $display("windowed_alpha_overlay_blend: mismatch");
        $finish;
    end

    // Fields from bit 0: column, row, pic b/g/r, logo b/g/r, alpha
    function automatic logic [79:0] pack_request(t_pixel_req r);
        return {r.logo_alpha, r.logo_red, r.logo_green, r.logo_blue,
                r.pic_red, r.pic_green, r.pic_blue, r.row, r.column};
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_pixel(t_pixel_req r);
        while (!no_gaps && $urandom_range(99) < 19) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  <= pack_request(r);
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic send_fields(int col, int row, int pb, int pg, int pr,
                               int lb, int lg, int lr, int alpha);
        t_pixel_req r;
        r.column     = 12'(col);
        r.row        = 12'(row);
        r.pic_blue   = 8'(pb);
        r.pic_green  = 8'(pg);
        r.pic_red    = 8'(pr);
        r.logo_blue  = 8'(lb);
        r.logo_green = 8'(lg);
        r.logo_red   = 8'(lr);
        r.logo_alpha = 8'(alpha);
        send_pixel(r);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // Two-phase APB write that leaves the bus idle afterwards; the shadow copy
    // follows at the write edge
    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Reprogram the overlay once the pipe is empty; junk_high fills unused bits
    task automatic apply_setup(t_overlay_setup s, bit junk_high);
        logic [31:0] junk;
        junk = junk_high ? $urandom : 32'd0;
        wait_drained();
        apb_write(REG_TRANSP,    {junk[31:8], s.transp});
        apb_write(REG_LOGO_LEFT, {junk[31:12], s.left});
        apb_write(REG_LOGO_TOP,  {junk[31:12], s.top});
        apb_write(REG_LOGO_COLS, {junk[31:13], s.lcols});
        apb_write(REG_LOGO_ROWS, {junk[31:13], s.lrows});
        apb_write(REG_PIC_COLS,  {junk[31:13], s.pcols});
        apb_write(REG_PIC_ROWS,  {junk[31:13], s.prows});
    endtask

    function automatic t_overlay_setup make_setup(int t, int l, int tp, int lc, int lr,
                                                  int pc, int pr);
        t_overlay_setup s;
        s.transp = 8'(t);
        s.left   = 12'(l);
        s.top    = 12'(tp);
        s.lcols  = 13'(lc);
        s.lrows  = 13'(lr);
        s.pcols  = 13'(pc);
        s.prows  = 13'(pr);
        return s;
    endfunction

    // Mostly valid overlays on small pictures, with bad transparency, misfit or empty logos, oversize pictures
    function automatic t_overlay_setup random_setup();
        int pc, pr, lc, lr, l, tp, t, pick;
        pick = $urandom_range(99);
        pc = ($urandom_range(9) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
        pr = ($urandom_range(9) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
        lc = $urandom_range(1, pc);
        lr = $urandom_range(1, pr);
        l  = $urandom_range(0, pc - lc);
        tp = $urandom_range(0, pr - lr);
        t  = $urandom_range(26, 230);
        if (pick < 6)       t  = $urandom_range(0, 25);
        else if (pick < 12) t  = $urandom_range(231, 255);
        else if (pick < 18) lc = pc - l + 1;
        else if (pick < 24) lr = pr - tp + 1;
        else if (pick < 28) pc = $urandom_range(4097, 8191);
        else if (pick < 31) lc = 0;
        else if (pick < 34) lr = 0;
        return make_setup(t, l, tp, lc, lr, pc, pr);
    endfunction

    // Coordinate around a window edge, clipped to the field range
    function automatic int near_span(int lo, int span);
        int a, b;
        a = (lo > 2) ? lo - 2 : 0;
        b = (lo + span + 1 > 4095) ? 4095 : lo + span + 1;
        return $urandom_range(a, b);
    endfunction

    task automatic send_random_pixel();
        t_pixel_req r;
        int         pick;
        r.column     = ($urandom_range(4) == 0) ? 12'($urandom)
                                                : 12'(near_span(sb.left, sb.lcols));
        r.row        = ($urandom_range(4) == 0) ? 12'($urandom)
                                                : 12'(near_span(sb.top, sb.lrows));
        r.pic_blue   = 8'($urandom);
        r.pic_green  = 8'($urandom);
        r.pic_red    = 8'($urandom);
        r.logo_blue  = 8'($urandom);
        r.logo_green = 8'($urandom);
        r.logo_red   = 8'($urandom);
        pick = $urandom_range(9);
        r.logo_alpha = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
        send_pixel(r);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset setup: 1x1 logo on a 1x1 picture
        send_fields(0, 0, 10, 20, 30, 200, 100, 50, 255);

        // Lowest transparency, logo covers the largest picture
        apply_setup(make_setup(26, 0, 0, 4096, 4096, 4096, 4096), 0);
        send_fields(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_fields(4095, 4095, 255, 255, 255, 255, 255, 255, 255);
        send_fields(1234, 2345, 77, 88, 99, 11, 22, 33, 0);
        send_fields(2047, 2048, 0, 0, 0, 255, 255, 255, 255);
        send_fields(3000, 1000, 255, 255, 255, 0, 0, 0, 128);

        // Highest transparency
        apply_setup(make_setup(230, 0, 0, 4096, 4096, 4096, 4096), 0);
        send_fields(5, 6, 0, 0, 0, 255, 255, 255, 255);
        send_fields(7, 8, 255, 255, 255, 255, 255, 255, 255);

        // Transparency just out of range, and at the far ends
        apply_setup(make_setup(25, 0, 0, 4096, 4096, 4096, 4096), 0);
        send_fields(1, 1, 10, 20, 30, 40, 50, 60, 255);
        wait_drained();
        apb_write(REG_TRANSP, 32'd231);
        send_fields(1, 1, 10, 20, 30, 40, 50, 60, 255);
        wait_drained();
        apb_write(REG_TRANSP, 32'd0);
        send_fields(1, 1, 10, 20, 30, 40, 50, 60, 255);
        wait_drained();
        apb_write(REG_TRANSP, 32'd255);
        send_fields(1, 1, 10, 20, 30, 40, 50, 60, 255);
        wait_drained();

        // Small window: edges inside and outside, pixel outside the picture
        apply_setup(make_setup(128, 10, 20, 5, 3, 16, 24), 0);
        // unmapped register address must be ignored
        apb_write(3'd7, 32'd0);
        send_fields(9, 20, 1, 2, 3, 200, 201, 202, 180);
        send_fields(10, 20, 1, 2, 3, 200, 201, 202, 180);
        send_fields(14, 22, 90, 91, 92, 10, 11, 12, 255);
        send_fields(15, 22, 90, 91, 92, 10, 11, 12, 255);
        send_fields(12, 23, 90, 91, 92, 10, 11, 12, 255);
        send_fields(100, 100, 90, 91, 92, 10, 11, 12, 255);

        // Logo does not fit across, then down
        apply_setup(make_setup(128, 12, 0, 5, 3, 16, 24), 0);
        send_fields(13, 1, 5, 6, 7, 8, 9, 10, 255);
        apply_setup(make_setup(128, 0, 22, 5, 3, 16, 24), 0);
        send_fields(1, 23, 5, 6, 7, 8, 9, 10, 255);

        // Picture larger than allowed
        apply_setup(make_setup(128, 0, 0, 4, 4, 8191, 4096), 0);
        send_fields(1, 1, 5, 6, 7, 8, 9, 10, 255);
        apply_setup(make_setup(128, 0, 0, 4, 4, 4096, 4097), 0);
        send_fields(1, 1, 5, 6, 7, 8, 9, 10, 255);

        // Empty logo in either direction
        apply_setup(make_setup(128, 0, 0, 0, 4, 16, 16), 0);
        send_fields(0, 0, 5, 6, 7, 8, 9, 10, 255);
        apply_setup(make_setup(128, 0, 0, 4, 0, 16, 16), 0);
        send_fields(0, 0, 5, 6, 7, 8, 9, 10, 255);

        // One-pixel logo in the far corner
        apply_setup(make_setup(100, 4095, 4095, 1, 1, 4096, 4096), 0);
        send_fields(4095, 4095, 50, 60, 70, 250, 240, 230, 200);
        send_fields(4094, 4095, 50, 60, 70, 250, 240, 230, 200);

        // Random phases: new setup each, one gap-free stretch, one full drain mid-phase
        for (int ph = 0; ph < 12; ph++) begin
            apply_setup(random_setup(), ph[0]);
            no_gaps = (ph == 5);
            for (int k = 0; k < 38; k++) begin
                if (ph == 3 && k == 19) wait_drained();
                send_random_pixel();
            end
        end
        no_gaps = 0;

        // Let the pipe empty, then keep watching for stray results before the verdict
        wait_drained();
        repeat (12) @(negedge i_clk);
        if (sb.errors == 0)
            $display("windowed_alpha_overlay_blend: match");
        else
            $display("windowed_alpha_overlay_blend: mismatch");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/waob_pkg.sv
rtl/core/waob_cfg.sv
rtl/core/waob_front.sv
rtl/core/waob_weight.sv
rtl/core/waob_mix.sv
rtl/core/windowed_alpha_overlay_blend.sv
dv/tb_windowed_alpha_overlay_blend.sv
